/* rtl/bcs_pkg.sv */
// Package with the item types, request codes and constants of the battery charge simulator.
package bcs_pkg;

    localparam logic [2:0] REQ_TICK       = 3'd0;
    localparam logic [2:0] REQ_POWER_HIGH = 3'd1;
    localparam logic [2:0] REQ_POWER_LOW  = 3'd2;
    localparam logic [2:0] REQ_TIMEOUT    = 3'd3;
    localparam logic [2:0] REQ_HEARTBEAT  = 3'd4;

    localparam logic [1:0] CFG_CHARGE_RATE    = 2'd0;
    localparam logic [1:0] CFG_DISCHARGE_RATE = 2'd1;

    localparam logic [30:0] FULL_LEVEL      = 31'd1677721600;
    localparam logic [30:0] STEP_MAX        = 31'h7FFF_FFFF;
    localparam logic [30:0] LEVEL_RESET     = 31'd838860800;
    localparam logic [15:0] CHARGE_RATE_RST = 16'd2431;
    localparam logic [15:0] DISCH_RATE_RST  = 16'd2605;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd60;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic [30:0] charge_level;
        logic        is_charging;
        logic        is_discharging;
        logic        heartbeat_expired;
        logic [15:0] heartbeat_age;
    } out_item_t;

endpackage

/* rtl/battery_charge_simulator_top.sv */
// Top level of the battery charge simulator: register stage, state update and result register.
// Items pass through the input register, then the result register; a new item is accepted every
// cycle unless an untaken result stalls it. The set point multiply and the tick's add and clamp
// each fit in the one stage between those two registers. The state of charge starts at 50 percent
// after reset; a write to the initial charge register (index 2) is accepted and has no effect on
// the running level. Charge and discharge rates take the low sixteen bits of the write data.
module battery_charge_simulator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bcs_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    logic               in_valid_reg;
    bcs_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    bcs_pkg::out_item_t out_item_reg;
    bcs_pkg::out_item_t out_item_next;
    logic               advance;

    logic [15:0] charge_rate_reg;
    logic [15:0] discharge_rate_reg;

    logic [30:0] soc_reg, soc_next;
    logic [30:0] charge_step_reg, charge_step_next;
    logic [30:0] discharge_step_reg, discharge_step_next;
    logic        charging_reg, charging_next;
    logic        discharging_reg, discharging_next;
    logic [15:0] power_high_reg, power_high_next;
    logic [15:0] beat_count_reg, beat_count_next;
    logic [15:0] beat_timeout_reg, beat_timeout_next;
    logic [15:0] beat_expected_reg, beat_expected_next;
    logic        expired;

    logic [31:0] set_point;
    logic [31:0] magnitude;
    logic [15:0] rate_sel;
    logic [47:0] product;
    logic [30:0] step_sat;
    logic [31:0] level_sum;
    logic [15:0] count_cleared;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_rate_reg    <= bcs_pkg::CHARGE_RATE_RST;
            discharge_rate_reg <= bcs_pkg::DISCH_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bcs_pkg::CFG_CHARGE_RATE:    charge_rate_reg    <= cfg_data[15:0];
                bcs_pkg::CFG_DISCHARGE_RATE: discharge_rate_reg <= cfg_data[15:0];
                default:                     ;
            endcase
        end
    end

    assign set_point = {power_high_reg, in_item_reg.write_value};
    assign magnitude = set_point[31] ? (~set_point + 32'd1) : set_point;
    assign rate_sel  = set_point[31] ? charge_rate_reg : discharge_rate_reg;
    assign product   = {16'd0, magnitude} * {32'd0, rate_sel};
    assign step_sat  = (product[47:31] != 17'd0) ? bcs_pkg::STEP_MAX : product[30:0];
    assign level_sum = {1'b0, soc_reg} + {1'b0, charge_step_reg};

    always_comb
    begin
        soc_next            = soc_reg;
        charge_step_next    = charge_step_reg;
        discharge_step_next = discharge_step_reg;
        charging_next       = charging_reg;
        discharging_next    = discharging_reg;
        power_high_next     = power_high_reg;
        beat_count_next     = beat_count_reg;
        beat_timeout_next   = beat_timeout_reg;
        beat_expected_next  = beat_expected_reg;
        expired             = 1'b0;
        count_cleared       = beat_count_reg;
        case (in_item_reg.req_type)
            bcs_pkg::REQ_TICK:
            begin
                if (beat_count_reg > beat_timeout_reg)
                begin
                    expired       = 1'b1;
                    count_cleared = 16'd0;
                end
                if (charging_reg)
                begin
                    if (level_sum <= {1'b0, bcs_pkg::FULL_LEVEL})
                    begin
                        soc_next = level_sum[30:0];
                    end
                    else
                    begin
                        soc_next      = bcs_pkg::FULL_LEVEL;
                        charging_next = 1'b0;
                    end
                end
                else if (discharging_reg)
                begin
                    if (soc_reg >= discharge_step_reg)
                    begin
                        soc_next = soc_reg - discharge_step_reg;
                    end
                    else
                    begin
                        soc_next         = 31'd0;
                        discharging_next = 1'b0;
                    end
                end
                beat_count_next = (count_cleared == bcs_pkg::COUNT_MAX) ?
                                  count_cleared : count_cleared + 16'd1;
            end
            bcs_pkg::REQ_POWER_HIGH:
            begin
                power_high_next = in_item_reg.write_value;
            end
            bcs_pkg::REQ_POWER_LOW:
            begin
                if (set_point[31])
                begin
                    charging_next    = 1'b1;
                    discharging_next = 1'b0;
                    charge_step_next = step_sat;
                end
                else if (set_point != 32'd0)
                begin
                    charging_next       = 1'b0;
                    discharging_next    = 1'b1;
                    discharge_step_next = step_sat;
                end
                else
                begin
                    charging_next    = 1'b0;
                    discharging_next = 1'b0;
                end
            end
            bcs_pkg::REQ_TIMEOUT:
            begin
                beat_timeout_next = in_item_reg.write_value;
                beat_count_next   = 16'd0;
            end
            bcs_pkg::REQ_HEARTBEAT:
            begin
                if (beat_expected_reg == in_item_reg.write_value)
                begin
                    beat_count_next = 16'd0;
                end
                beat_expected_next = ~in_item_reg.write_value;
            end
            default: ;
        endcase
        out_item_next.charge_level      = soc_next;
        out_item_next.is_charging       = charging_next;
        out_item_next.is_discharging    = discharging_next;
        out_item_next.heartbeat_expired = expired;
        out_item_next.heartbeat_age     = beat_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            soc_reg            <= bcs_pkg::LEVEL_RESET;
            charge_step_reg    <= 31'd0;
            discharge_step_reg <= 31'd0;
            charging_reg       <= 1'b0;
            discharging_reg    <= 1'b0;
            power_high_reg     <= 16'd0;
            beat_count_reg     <= 16'd0;
            beat_timeout_reg   <= bcs_pkg::TIMEOUT_RESET;
            beat_expected_reg  <= 16'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                soc_reg            <= soc_next;
                charge_step_reg    <= charge_step_next;
                discharge_step_reg <= discharge_step_next;
                charging_reg       <= charging_next;
                discharging_reg    <= discharging_next;
                power_high_reg     <= power_high_next;
                beat_count_reg     <= beat_count_next;
                beat_timeout_reg   <= beat_timeout_next;
                beat_expected_reg  <= beat_expected_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(charging_reg && discharging_reg))
        else $error("Charging and discharging are both set.");

    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        soc_reg <= bcs_pkg::FULL_LEVEL)
        else $error("State of charge is above full.");

    a_expired_age: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.heartbeat_expired) |-> (out_item_reg.heartbeat_age == 16'd1))
        else $error("An expired heartbeat item does not report an age of one.");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("A stalled item left the input register.");
`endif

endmodule

/* dv/charge_state_checker.sv */
// Checker that predicts the battery state from accepted items and compares every result.
module charge_state_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  bcs_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  bcs_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    output int                 fail_count,
    output int                 status_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [15:0] charge_rate;
    logic [15:0] discharge_rate;
    logic [30:0] soc;
    logic [30:0] charge_step;
    logic [30:0] discharge_step;
    logic        charging;
    logic        discharging;
    logic [15:0] power_high;
    logic [15:0] beat_count;
    logic [15:0] beat_timeout;
    logic [15:0] beat_expected;

    bcs_pkg::out_item_t predicted_status[$];

    initial fail_count = 0;

    function automatic logic [30:0] scale_step(logic [31:0] magnitude, logic [15:0] rate);
        logic [47:0] product;
        product = 48'(magnitude) * 48'(rate);
        if (product > 48'(bcs_pkg::STEP_MAX))
            return bcs_pkg::STEP_MAX;
        return product[30:0];
    endfunction

    function automatic bcs_pkg::out_item_t advance_battery(bcs_pkg::in_item_t item);
        bcs_pkg::out_item_t status;
        logic [31:0]        setpoint;
        logic [31:0]        total;
        logic               expired;
        expired = 1'b0;
        case (item.req_type)
            bcs_pkg::REQ_TICK:
            begin
                if (beat_count > beat_timeout)
                begin
                    expired = 1'b1;
                    beat_count = '0;
                end
                if (charging)
                begin
                    total = {1'b0, soc} + {1'b0, charge_step};
                    if (total <= {1'b0, bcs_pkg::FULL_LEVEL})
                        soc = total[30:0];
                    else
                    begin
                        soc = bcs_pkg::FULL_LEVEL;
                        charging = 1'b0;
                    end
                end
                else if (discharging)
                begin
                    if (soc >= discharge_step)
                        soc = soc - discharge_step;
                    else
                    begin
                        soc = '0;
                        discharging = 1'b0;
                    end
                end
                if (beat_count < bcs_pkg::COUNT_MAX)
                    beat_count = beat_count + 16'd1;
            end
            bcs_pkg::REQ_POWER_HIGH:
                power_high = item.write_value;
            bcs_pkg::REQ_POWER_LOW:
            begin
                setpoint = {power_high, item.write_value};
                if (setpoint[31])
                begin
                    charging = 1'b1;
                    discharging = 1'b0;
                    charge_step = scale_step(~setpoint + 32'd1, charge_rate);
                end
                else if (setpoint != '0)
                begin
                    charging = 1'b0;
                    discharging = 1'b1;
                    discharge_step = scale_step(setpoint, discharge_rate);
                end
                else
                begin
                    charging = 1'b0;
                    discharging = 1'b0;
                end
            end
            bcs_pkg::REQ_TIMEOUT:
            begin
                beat_timeout = item.write_value;
                beat_count = '0;
            end
            bcs_pkg::REQ_HEARTBEAT:
            begin
                if (beat_expected == item.write_value)
                    beat_count = '0;
                beat_expected = ~item.write_value;
            end
            default:
                ;
        endcase
        status.charge_level = soc;
        status.is_charging = charging;
        status.is_discharging = discharging;
        status.heartbeat_expired = expired;
        status.heartbeat_age = beat_count;
        return status;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bcs_pkg::out_item_t want;
        if (!rst_n)
        begin
            charge_rate = bcs_pkg::CHARGE_RATE_RST;
            discharge_rate = bcs_pkg::DISCH_RATE_RST;
            soc = bcs_pkg::LEVEL_RESET;
            charge_step = '0;
            discharge_step = '0;
            charging = 1'b0;
            discharging = 1'b0;
            power_high = '0;
            beat_count = '0;
            beat_timeout = bcs_pkg::TIMEOUT_RESET;
            beat_expected = '0;
            predicted_status.delete();
            status_backlog <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bcs_pkg::CFG_CHARGE_RATE:    charge_rate = cfg_data[15:0];
                    bcs_pkg::CFG_DISCHARGE_RATE: discharge_rate = cfg_data[15:0];
                    default:                     ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"%0t: result with no item pending:",
                                  " level=%0d chg=%0b dis=%0b exp=%0b age=%0d"},
                                 $realtime, out_data.charge_level, out_data.is_charging,
                                 out_data.is_discharging, out_data.heartbeat_expired,
                                 out_data.heartbeat_age);
                end
                else
                begin
                    want = predicted_status.pop_front();
                    if (out_data.charge_level !== want.charge_level
                        || out_data.is_charging !== want.is_charging
                        || out_data.is_discharging !== want.is_discharging
                        || out_data.heartbeat_expired !== want.heartbeat_expired
                        || out_data.heartbeat_age !== want.heartbeat_age)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch: expected level=%0d chg=%0b",
                                      " dis=%0b exp=%0b age=%0d,",
                                      " got level=%0d chg=%0b dis=%0b exp=%0b age=%0d"},
                                     $realtime, want.charge_level, want.is_charging,
                                     want.is_discharging, want.heartbeat_expired,
                                     want.heartbeat_age, out_data.charge_level,
                                     out_data.is_charging, out_data.is_discharging,
                                     out_data.heartbeat_expired, out_data.heartbeat_age);
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_status.push_back(advance_battery(in_data));
            status_backlog <= predicted_status.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Top of the battery charge simulator testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_INITIAL_CHARGE = 2'd2;
    localparam logic [2:0] REQ_UNUSED_FIRST   = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST    = 3'd7;
    localparam int         HOLD_CYCLES        = 300;
    localparam int         QUIET_LIMIT        = 3000;
    localparam int         BURST_ITEMS        = 75;
    localparam int         FINAL_TICKS        = 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    bcs_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    bcs_pkg::out_item_t out_data;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [30:0]        cfg_data = '0;

    int          fail_count;
    int          status_backlog;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_request = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    logic [15:0] beat_guess = '0;

    battery_charge_simulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    charge_state_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .status_backlog (status_backlog)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic offer_request(logic [2:0] req, logic [15:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.req_type <= req;
        in_data.write_value <= value;
        if (req == bcs_pkg::REQ_HEARTBEAT)
            beat_guess = ~value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (status_backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [30:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_rates(logic [15:0] charge, logic [15:0] discharge,
                                 logic [30:0] start_level);
        write_register(bcs_pkg::CFG_CHARGE_RATE, {15'($urandom), charge});
        write_register(bcs_pkg::CFG_DISCHARGE_RATE, {15'($urandom), discharge});
        write_register(CFG_INITIAL_CHARGE, start_level);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_setpoint();
        case ($urandom_range(5))
            0:       return 32'($urandom_range(1, 5000));
            1:       return 32'd0 - 32'($urandom_range(1, 5000));
            2:       return $urandom;
            3:       return 32'd0;
            4:       return 32'h8000_0000;
            default: return 32'd0 - 32'($urandom_range(1, 200000));
        endcase
    endfunction

    task automatic send_random_burst(int count);
        int          sent;
        int          pick;
        int          extra;
        logic [31:0] setpoint;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                setpoint = pick_setpoint();
                offer_request(bcs_pkg::REQ_POWER_HIGH, setpoint[31:16]);
                offer_request(bcs_pkg::REQ_POWER_LOW, setpoint[15:0]);
                extra = $urandom_range(0, 2);
                repeat (extra) offer_request(bcs_pkg::REQ_POWER_LOW, 16'($urandom));
                sent += 2 + extra;
            end
            else if (pick < 65)
            begin
                extra = $urandom_range(1, 6);
                repeat (extra) offer_request(bcs_pkg::REQ_TICK, 16'($urandom));
                sent += extra;
            end
            else if (pick < 75)
            begin
                if ($urandom_range(3) == 0)
                    offer_request(bcs_pkg::REQ_TIMEOUT, 16'($urandom));
                else
                    offer_request(bcs_pkg::REQ_TIMEOUT, 16'($urandom_range(0, 8)));
                sent += 1;
            end
            else if (pick < 90)
            begin
                if ($urandom_range(3) == 0)
                    offer_request(bcs_pkg::REQ_HEARTBEAT, 16'($urandom));
                else
                    offer_request(bcs_pkg::REQ_HEARTBEAT, beat_guess);
                sent += 1;
            end
            else
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        offer_request(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                                      16'($urandom));
                        sent += 1;
                    end
                    1:
                    begin
                        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'($urandom));
                        sent += 1;
                    end
                    default:
                    begin
                        offer_request(bcs_pkg::REQ_POWER_LOW, 16'($urandom));
                        sent += 1;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(bcs_pkg::REQ_TICK, 16'hFFFF);
        offer_request(bcs_pkg::REQ_HEARTBEAT, 16'h0000);
        offer_request(bcs_pkg::REQ_TIMEOUT, 16'd2);
        repeat (4) offer_request(bcs_pkg::REQ_TICK, 16'h0000);
        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'h8000);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'h0000);
        offer_request(bcs_pkg::REQ_TICK, 16'h5A5A);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'h0001);
        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'h7FFF);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'hFFFF);
        offer_request(bcs_pkg::REQ_TICK, 16'hA5A5);
        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'h0000);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'h0000);
        for (int r = REQ_UNUSED_FIRST; r <= REQ_UNUSED_LAST; r++)
            offer_request(3'(r), 16'hFFFF);
        offer_request(bcs_pkg::REQ_HEARTBEAT, 16'hFFFF);
        offer_request(bcs_pkg::REQ_TIMEOUT, 16'hFFFF);
        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'hFFFF);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'hF448);
        offer_request(bcs_pkg::REQ_TICK, 16'h0000);
        offer_request(bcs_pkg::REQ_POWER_HIGH, 16'h0000);
        offer_request(bcs_pkg::REQ_POWER_LOW, 16'd3000);
        offer_request(bcs_pkg::REQ_TICK, 16'h0000);
        settle();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: program_rates(16'd0, 16'd0, 31'd0);
                2: program_rates(16'hFFFF, 16'hFFFF, bcs_pkg::FULL_LEVEL);
                3: program_rates(16'($urandom), 16'($urandom),
                                 31'($urandom_range(0, bcs_pkg::FULL_LEVEL)));
                4: program_rates(16'd1, 16'hFFFF,
                                 31'($urandom_range(0, bcs_pkg::FULL_LEVEL)));
                5: program_rates(16'hFFFF, 16'd1,
                                 31'($urandom_range(0, bcs_pkg::FULL_LEVEL)));
                default: ;
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct = 29;
                    recv_stall_pct = 29;
                end
            endcase
            if (phase == 0)
                hold_request = 1'b1;
            send_random_burst(BURST_ITEMS);
            settle();
        end

        program_rates(16'($urandom), 16'($urandom),
                      31'($urandom_range(0, bcs_pkg::FULL_LEVEL)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        offer_request(bcs_pkg::REQ_TIMEOUT, 16'hFFFF);
        repeat (FINAL_TICKS) offer_request(bcs_pkg::REQ_TICK, 16'($urandom));
        settle();

        if (fail_count == 0 && status_backlog == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
